// ===== rtl/core/qrs_pkg.sv =====
package qrs_pkg;

    localparam int COEF_W = 16;
    localparam int FRAC_SHIFT = 16;
    localparam int DISC_W = 34;
    localparam int ROOT_W = 40;
    localparam int THR_W = 16;
    localparam int RAD_W = 50;
    localparam int SQ_W = 25;
    localparam int NUM_W = 34;
    localparam int NUMS_W = 36;
    localparam int DEN_W = 17;
    localparam int DENS_W = 18;
    localparam int CMP_W = 51;

    typedef enum logic [2:0] {
        ST_TWO    = 3'd0,
        ST_NONE   = 3'd1,
        ST_LINEAR = 3'd2,
        ST_ZERO   = 3'd3,
        ST_NOSOL  = 3'd4
    } status_t;

    typedef struct packed {
        logic [RAD_W-1:0] rem;
        logic [SQ_W-1:0]  root;
    } sqrt_t;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [NUM_W-1:0] quot;
        logic [DEN_W-1:0] den;
    } div_t;

    typedef struct packed {
        logic signed [DISC_W-1:0] disc;
        status_t                  st;
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
    } side_t;

    typedef struct packed {
        logic signed [DISC_W-1:0] disc;
        status_t                  st;
        logic                     neg_plus;
        logic                     neg_minus;
    } dside_t;

endpackage

// ===== rtl/core/qrs_sqrt_cell.sv =====
module qrs_sqrt_cell #(
    parameter int BIT = 0
) (
    input  logic          clk,
    input  logic          en,
    input  qrs_pkg::sqrt_t din,
    output qrs_pkg::sqrt_t dout
);

    logic [qrs_pkg::CMP_W-1:0] trial;
    logic [qrs_pkg::CMP_W-1:0] rem_ext;
    qrs_pkg::sqrt_t data_next;
    qrs_pkg::sqrt_t data_reg;

    always_comb
    begin
        trial = (qrs_pkg::CMP_W'(din.root) << (BIT + 1))
              + (qrs_pkg::CMP_W'(1) << (2 * BIT));
        rem_ext = qrs_pkg::CMP_W'(din.rem);
        data_next = din;
        if (rem_ext >= trial)
        begin
            data_next.rem = qrs_pkg::RAD_W'(rem_ext - trial);
            data_next.root = din.root | (qrs_pkg::SQ_W'(1) << BIT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign dout = data_reg;

endmodule

// ===== rtl/core/qrs_div_cell.sv =====
module qrs_div_cell #(
    parameter int BIT = 0
) (
    input  logic         clk,
    input  logic         en,
    input  qrs_pkg::div_t din,
    output qrs_pkg::div_t dout
);

    logic [qrs_pkg::CMP_W-1:0] trial;
    logic [qrs_pkg::CMP_W-1:0] rem_ext;
    qrs_pkg::div_t data_next;
    qrs_pkg::div_t data_reg;

    always_comb
    begin
        trial = qrs_pkg::CMP_W'(din.den) << BIT;
        rem_ext = qrs_pkg::CMP_W'(din.rem);
        data_next = din;
        if (rem_ext >= trial)
        begin
            data_next.rem = qrs_pkg::NUM_W'(rem_ext - trial);
            data_next.quot = din.quot | (qrs_pkg::NUM_W'(1) << BIT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign dout = data_reg;

endmodule

// ===== rtl/core/quadratic_root_solver.sv =====
// Throughput: one request per cycle; the whole pipeline stalls only while
// the output register holds a result that is not taken.
// The pipeline is 25 square root cells followed by two chains of 34 divider cells, one chain per root.
// Reset clears all valid bits and loads the threshold with 65.
module quadratic_root_solver (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // coef_square [15:0], coef_linear [31:16], coef_constant [47:32]
    input  logic [47:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // discriminant_out [33:0], root_plus [73:34], root_minus [113:74], zero fill
    output logic [119:0] m_axis_tdata,
    // status [2:0]
    output logic [2:0]   m_axis_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data
);

    localparam int SQ_W = qrs_pkg::SQ_W;
    localparam int NUM_W = qrs_pkg::NUM_W;
    localparam int COEF_W = qrs_pkg::COEF_W;
    localparam int DISC_W = qrs_pkg::DISC_W;
    localparam int ROOT_W = qrs_pkg::ROOT_W;
    localparam int NUMS_W = qrs_pkg::NUMS_W;
    localparam int DENS_W = qrs_pkg::DENS_W;

    logic adv;
    logic [qrs_pkg::THR_W-1:0] thr_reg;

    logic v1_reg;
    logic signed [COEF_W-1:0] a1_reg, b1_reg, c1_reg;
    logic v2_reg;
    logic signed [2*COEF_W-1:0] bb2_reg, ac2_reg;
    logic signed [COEF_W-1:0] a2_reg, b2_reg, c2_reg;

    logic signed [DISC_W-1:0] disc_raw, disc_c;
    qrs_pkg::status_t st3;
    qrs_pkg::sqrt_t sq_in_next;
    qrs_pkg::sqrt_t sq_in_reg;
    qrs_pkg::side_t side_in_next;

    qrs_pkg::sqrt_t sq [0:SQ_W];
    qrs_pkg::side_t sside_reg [0:SQ_W];
    logic [SQ_W:0] vs_reg;

    qrs_pkg::side_t sd;
    logic signed [NUMS_W-1:0] nb, s_ext, num_p, num_m, num_l, np_sel, nm_sel;
    logic signed [DENS_W-1:0] den_sel;
    logic [NUMS_W-1:0] mag_p, mag_m;
    logic [DENS_W-1:0] mag_d;
    qrs_pkg::div_t dp_next, dm_next;
    qrs_pkg::dside_t dside_next;

    qrs_pkg::div_t dvp [0:NUM_W];
    qrs_pkg::div_t dvm [0:NUM_W];
    qrs_pkg::div_t dvp_in_reg, dvm_in_reg;
    qrs_pkg::dside_t dside_reg [0:NUM_W];
    logic [NUM_W:0] vd_reg;

    logic signed [ROOT_W-1:0] rp_next, rm_next;
    logic out_valid_reg;
    logic signed [DISC_W-1:0] disc_out_reg;
    logic signed [ROOT_W-1:0] rp_reg, rm_reg;
    qrs_pkg::status_t st_out_reg;

    assign adv = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= qrs_pkg::THR_W'(65);
        end
        else if (cfg_valid)
        begin
            thr_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vs_reg <= '0;
            vd_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            vs_reg <= {vs_reg[SQ_W-1:0], v2_reg};
            vd_reg <= {vd_reg[NUM_W-1:0], vs_reg[SQ_W]};
            out_valid_reg <= vd_reg[NUM_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a1_reg <= s_axis_tdata[15:0];
            b1_reg <= s_axis_tdata[31:16];
            c1_reg <= s_axis_tdata[47:32];
            bb2_reg <= b1_reg * b1_reg;
            ac2_reg <= a1_reg * c1_reg;
            a2_reg <= a1_reg;
            b2_reg <= b1_reg;
            c2_reg <= c1_reg;
        end
    end

    always_comb
    begin
        disc_raw = DISC_W'(bb2_reg) - (DISC_W'(ac2_reg) <<< 2);
        disc_c = disc_raw;
        if (disc_raw > 0
            && disc_raw[DISC_W-2:0] < (DISC_W-1)'(thr_reg))
        begin
            disc_c = '0;
        end
        if (disc_c < 0)
        begin
            st3 = qrs_pkg::ST_NONE;
        end
        else if (a2_reg == 0)
        begin
            if (c2_reg == 0)
            begin
                st3 = (b2_reg == 0) ? qrs_pkg::ST_ZERO : qrs_pkg::ST_LINEAR;
            end
            else if (b2_reg == 0)
            begin
                st3 = qrs_pkg::ST_NOSOL;
            end
            else
            begin
                st3 = qrs_pkg::ST_LINEAR;
            end
        end
        else
        begin
            st3 = qrs_pkg::ST_TWO;
        end
        sq_in_next.root = '0;
        sq_in_next.rem = disc_c[DISC_W-1] ? '0
            : qrs_pkg::RAD_W'({disc_c[DISC_W-2:0], {qrs_pkg::FRAC_SHIFT{1'b0}}});
        side_in_next.disc = disc_c;
        side_in_next.st = st3;
        side_in_next.a = a2_reg;
        side_in_next.b = b2_reg;
        side_in_next.c = c2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_in_reg <= sq_in_next;
            sside_reg[0] <= side_in_next;
            for (int k = 1; k <= SQ_W; k++)
            begin
                sside_reg[k] <= sside_reg[k-1];
            end
        end
    end

    assign sq[0] = sq_in_reg;

    for (genvar k = 0; k < SQ_W; k++)
    begin : g_sqrt
        qrs_sqrt_cell #(
            .BIT(SQ_W - 1 - k)
        ) u_cell (
            .clk (clk),
            .en  (adv),
            .din (sq[k]),
            .dout(sq[k+1])
        );
    end

    always_comb
    begin
        sd = sside_reg[SQ_W];
        nb = -(NUMS_W'(sd.b) <<< 8);
        s_ext = $signed({{(NUMS_W-SQ_W){1'b0}}, sq[SQ_W].root});
        num_p = (nb + s_ext) <<< 8;
        num_m = (nb - s_ext) <<< 8;
        num_l = -(NUMS_W'(sd.c) <<< qrs_pkg::FRAC_SHIFT);
        if (sd.st == qrs_pkg::ST_LINEAR)
        begin
            np_sel = num_l;
            nm_sel = num_l;
            den_sel = DENS_W'(sd.b);
        end
        else
        begin
            np_sel = num_p;
            nm_sel = num_m;
            den_sel = DENS_W'(sd.a) <<< 1;
        end
        mag_p = np_sel[NUMS_W-1] ? NUMS_W'(-np_sel) : NUMS_W'(np_sel);
        mag_m = nm_sel[NUMS_W-1] ? NUMS_W'(-nm_sel) : NUMS_W'(nm_sel);
        mag_d = den_sel[DENS_W-1] ? DENS_W'(-den_sel) : DENS_W'(den_sel);
        dp_next.rem = mag_p[NUM_W-1:0];
        dp_next.quot = '0;
        dp_next.den = mag_d[qrs_pkg::DEN_W-1:0];
        dm_next.rem = mag_m[NUM_W-1:0];
        dm_next.quot = '0;
        dm_next.den = mag_d[qrs_pkg::DEN_W-1:0];
        dside_next.disc = sd.disc;
        dside_next.st = sd.st;
        dside_next.neg_plus = np_sel[NUMS_W-1] ^ den_sel[DENS_W-1];
        dside_next.neg_minus = nm_sel[NUMS_W-1] ^ den_sel[DENS_W-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dvp_in_reg <= dp_next;
            dvm_in_reg <= dm_next;
            dside_reg[0] <= dside_next;
            for (int k = 1; k <= NUM_W; k++)
            begin
                dside_reg[k] <= dside_reg[k-1];
            end
        end
    end

    assign dvp[0] = dvp_in_reg;
    assign dvm[0] = dvm_in_reg;

    for (genvar k = 0; k < NUM_W; k++)
    begin : g_div
        qrs_div_cell #(
            .BIT(NUM_W - 1 - k)
        ) u_plus (
            .clk (clk),
            .en  (adv),
            .din (dvp[k]),
            .dout(dvp[k+1])
        );
        qrs_div_cell #(
            .BIT(NUM_W - 1 - k)
        ) u_minus (
            .clk (clk),
            .en  (adv),
            .din (dvm[k]),
            .dout(dvm[k+1])
        );
    end

    always_comb
    begin
        rp_next = dside_reg[NUM_W].neg_plus ? -ROOT_W'(dvp[NUM_W].quot)
                                            : ROOT_W'(dvp[NUM_W].quot);
        rm_next = dside_reg[NUM_W].neg_minus ? -ROOT_W'(dvm[NUM_W].quot)
                                             : ROOT_W'(dvm[NUM_W].quot);
        if (dside_reg[NUM_W].st != qrs_pkg::ST_TWO
            && dside_reg[NUM_W].st != qrs_pkg::ST_LINEAR)
        begin
            rp_next = '0;
            rm_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            disc_out_reg <= dside_reg[NUM_W].disc;
            st_out_reg <= dside_reg[NUM_W].st;
            rp_reg <= rp_next;
            rm_reg <= rm_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {6'b0, rm_reg, rp_reg, disc_out_reg};
    assign m_axis_tuser = st_out_reg;

    a_zero_roots: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (st_out_reg == qrs_pkg::ST_NONE
            || st_out_reg == qrs_pkg::ST_ZERO || st_out_reg == qrs_pkg::ST_NOSOL)
        |-> rp_reg == 0 && rm_reg == 0)
        else $error("roots not cleared for a rootless status");

    a_none_negative: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && st_out_reg == qrs_pkg::ST_NONE |-> disc_out_reg < 0)
        else $error("no-roots status with a nonnegative discriminant");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> vs_reg == $past(vs_reg) && vd_reg == $past(vd_reg))
        else $error("pipeline moved during a stall");

endmodule
